@@ hw/rtl/rmst_pkg.sv @@
// shared types and codes for the range modulo sum tree block
package rmst_pkg;

  localparam int SUM_W = 42;
  localparam int VAL_W = 32;
  localparam int IDX_W = 10;
  localparam int LEN_W = 11;

  localparam logic [1:0] OP_SUM = 2'd0;
  localparam logic [1:0] OP_MOD = 2'd1;
  localparam logic [1:0] OP_SET = 2'd2;

  typedef enum logic [1:0] {
    KIND_SUM,
    KIND_MOD,
    KIND_SET,
    KIND_BAD
  } kind_t;

  typedef struct packed {
    logic [1:0]       operation;
    logic [IDX_W-1:0] left_index;
    logic [IDX_W-1:0] right_index;
    logic [VAL_W-1:0] operand_value;
  } in_item_t;

  typedef struct packed {
    logic [SUM_W-1:0] range_total;
    logic             bad_request;
  } out_item_t;

  typedef struct packed {
    kind_t            kind;
    logic [IDX_W-1:0] left_index;
    logic [IDX_W-1:0] right_index;
    logic [VAL_W-1:0] operand_value;
  } job_t;

endpackage

@@ hw/rtl/rmst_ram.sv @@
// generic single write port, single read port ram with registered read
module rmst_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ hw/rtl/rmst_div.sv @@
// iterative restoring modulo unit, one quotient bit per cycle
module rmst_div (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [31:0] dividend,
  input  logic [31:0] divisor,
  output logic        done,
  output logic [31:0] remainder
);

  logic        busy;
  logic [4:0]  cnt;
  logic [31:0] dvd;
  logic [31:0] rem;
  logic [32:0] shifted;
  logic [32:0] trial;
  logic        ge;

  always_comb begin
    shifted = {rem, dvd[31]};
    trial   = shifted - {1'b0, divisor};
    ge      = shifted >= {1'b0, divisor};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 5'd1;
        if (cnt == 5'd31) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dvd <= dividend;
      rem <= '0;
    end else if (busy) begin
      dvd <= {dvd[30:0], 1'b0};
      rem <= ge ? trial[31:0] : shifted[31:0];
    end
  end

  assign remainder = rem;

endmodule

@@ hw/rtl/rmst_front.sv @@
// front end: checks and classifies requests, holds them in a two-entry queue
module rmst_front #(
  parameter int LEAVES = 1024,
  localparam int LW = $clog2(LEAVES + 1)
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  input  rmst_pkg::in_item_t request,
  output logic               full,
  input  logic [LW-1:0]      len,
  input  logic               clearing,
  output logic               job_valid,
  output rmst_pkg::job_t     job,
  input  logic               job_take
);

  rmst_pkg::job_t q [2];
  logic           wr;
  logic           rd;
  logic [1:0]     cnt;
  logic           accept;
  logic           range_ok;
  logic           left_ok;
  rmst_pkg::job_t fresh;

  always_comb begin
    range_ok = (request.left_index <= request.right_index) &&
               (32'(request.right_index) < 32'(len));
    left_ok  = 32'(request.left_index) < 32'(len);
    fresh.left_index    = request.left_index;
    fresh.right_index   = request.right_index;
    fresh.operand_value = request.operand_value;
    case (request.operation)
      rmst_pkg::OP_SUM: fresh.kind = range_ok ? rmst_pkg::KIND_SUM : rmst_pkg::KIND_BAD;
      rmst_pkg::OP_MOD: fresh.kind = (range_ok && request.operand_value != '0) ?
                                     rmst_pkg::KIND_MOD : rmst_pkg::KIND_BAD;
      rmst_pkg::OP_SET: fresh.kind = left_ok ? rmst_pkg::KIND_SET : rmst_pkg::KIND_BAD;
      default:          fresh.kind = rmst_pkg::KIND_BAD;
    endcase
  end

  assign full      = (cnt == 2'd2) || clearing;
  assign accept    = push && !full;
  assign job_valid = cnt != 2'd0;
  assign job       = q[rd];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr  <= 1'b0;
      rd  <= 1'b0;
      cnt <= '0;
    end else begin
      if (accept) begin
        wr <= !wr;
      end
      if (job_take) begin
        rd <= !rd;
      end
      cnt <= cnt + {1'b0, accept} - {1'b0, job_take};
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      q[wr] <= fresh;
    end
  end

endmodule

@@ hw/rtl/rmst_back.sv @@
// back end: walks the element store for sums, modulo and assigns
module rmst_back #(
  parameter int LEAVES = 1024,
  localparam int AW = $clog2(LEAVES)
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                job_valid,
  input  rmst_pkg::job_t      job,
  output logic                job_take,
  output logic                clearing,
  output logic                empty,
  input  logic                pop,
  output rmst_pkg::out_item_t result
);

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_FETCH,
    S_EXAM,
    S_DIVIDE,
    S_REPLY
  } state_t;

  state_t                      state;
  logic [AW-1:0]               idx;
  logic [AW-1:0]               last;
  rmst_pkg::kind_t             kind;
  logic [rmst_pkg::VAL_W-1:0]  x;
  logic [rmst_pkg::SUM_W-1:0]  acc;
  logic [rmst_pkg::SUM_W-1:0]  acc_next;
  rmst_pkg::out_item_t         res;
  logic                        out_valid;
  logic                        load_res;

  logic                        we;
  logic [AW-1:0]               waddr;
  logic [rmst_pkg::VAL_W-1:0]  wdata;
  logic [rmst_pkg::VAL_W-1:0]  rdata;
  logic                        div_start;
  logic                        div_done;
  logic [rmst_pkg::VAL_W-1:0]  div_rem;
  logic                        at_last;

  rmst_ram #(.WIDTH(rmst_pkg::VAL_W), .DEPTH(LEAVES)) u_ram (
    .clk  (clk),
    .we   (we),
    .waddr(waddr),
    .wdata(wdata),
    .raddr(idx),
    .rdata(rdata)
  );

  rmst_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (rdata),
    .divisor  (x),
    .done     (div_done),
    .remainder(div_rem)
  );

  assign clearing  = state == S_CLEAR;
  assign job_take  = (state == S_IDLE) && job_valid;
  assign at_last   = idx == last;
  assign acc_next  = acc + rmst_pkg::SUM_W'(rdata);
  assign div_start = (state == S_EXAM) && (kind == rmst_pkg::KIND_MOD) && (rdata >= x);
  assign empty     = !out_valid;
  assign load_res  = (state == S_REPLY) && (!out_valid || pop);

  always_comb begin
    we    = 1'b0;
    waddr = idx;
    wdata = div_rem;
    case (state)
      S_CLEAR: begin
        we    = 1'b1;
        wdata = '0;
      end
      S_IDLE: begin
        we    = job_valid && (job.kind == rmst_pkg::KIND_SET);
        waddr = AW'(job.left_index);
        wdata = job.operand_value;
      end
      S_DIVIDE: we = div_done;
      default: we = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      idx       <= '0;
      out_valid <= 1'b0;
    end else begin
      if (load_res) begin
        out_valid <= 1'b1;
      end else if (pop && out_valid) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_CLEAR: begin
          idx <= idx + AW'(1);
          if (idx == AW'(LEAVES - 1)) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (job_valid) begin
            kind <= job.kind;
            x    <= job.operand_value;
            idx  <= AW'(job.left_index);
            last <= AW'(job.right_index);
            acc  <= '0;
            case (job.kind)
              rmst_pkg::KIND_SUM, rmst_pkg::KIND_MOD: state <= S_FETCH;
              rmst_pkg::KIND_BAD: begin
                res.range_total <= '0;
                res.bad_request <= 1'b1;
                state           <= S_REPLY;
              end
              default: state <= S_IDLE;
            endcase
          end
        end
        // read address goes out here, data is back in the exam cycle
        S_FETCH: state <= S_EXAM;
        S_EXAM: begin
          if (kind == rmst_pkg::KIND_SUM) begin
            acc <= acc_next;
            if (at_last) begin
              res.range_total <= acc_next;
              res.bad_request <= 1'b0;
              state           <= S_REPLY;
            end else begin
              idx   <= idx + AW'(1);
              state <= S_FETCH;
            end
          end else if (div_start) begin
            state <= S_DIVIDE;
          end else if (at_last) begin
            state <= S_IDLE;
          end else begin
            idx   <= idx + AW'(1);
            state <= S_FETCH;
          end
        end
        S_DIVIDE: begin
          if (div_done) begin
            if (at_last) begin
              state <= S_IDLE;
            end else begin
              idx   <= idx + AW'(1);
              state <= S_FETCH;
            end
          end
        end
        S_REPLY: begin
          if (load_res) begin
            result <= res;
            state  <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

@@ hw/rtl/range_modulo_sum_tree.sv @@
// top level of the range modulo sum store
//
//  channel  | handshake          | beat
//  ---------+--------------------+------------------------------------------
//  request  | push / full        | operation, left/right index, operand
//  result   | pop / empty        | range_total, bad_request
//  config   | cfg_valid/ready    | length_in_use (11 bit)
//
// a query reads its range element by element, a fetch and an exam state per
// element, through the one read port of the element ram; a modulo also runs the
// iterative modulo unit per element that is at least the modulus; an assign is
// written in idle. after reset the ram is swept to zero with full held high.
// a two-entry request queue lets requests queue while the back end works, and
// the result register lets the next request run while a result waits for pop.
module range_modulo_sum_tree #(
  parameter int LEAVES = 1024
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         push,
  output logic                         full,
  input  rmst_pkg::in_item_t           request,
  output logic                         empty,
  input  logic                         pop,
  output rmst_pkg::out_item_t          result,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [rmst_pkg::LEN_W-1:0]   cfg_data
);

  localparam int LW = $clog2(LEAVES + 1);

  logic [LW-1:0]  len;
  logic           clearing;
  logic           job_valid;
  logic           job_take;
  rmst_pkg::job_t job;

  assign cfg_ready = 1'b1;

  // length is clamped to 1..LEAVES when written
  always_ff @(posedge clk) begin
    if (rst) begin
      len <= LW'(LEAVES);
    end else if (cfg_valid && cfg_ready) begin
      if (cfg_data == '0) begin
        len <= LW'(1);
      end else if (32'(cfg_data) > LEAVES) begin
        len <= LW'(LEAVES);
      end else begin
        len <= LW'(cfg_data);
      end
    end
  end

  rmst_front #(.LEAVES(LEAVES)) u_front (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .request  (request),
    .full     (full),
    .len      (len),
    .clearing (clearing),
    .job_valid(job_valid),
    .job      (job),
    .job_take (job_take)
  );

  rmst_back #(.LEAVES(LEAVES)) u_back (
    .clk      (clk),
    .rst      (rst),
    .job_valid(job_valid),
    .job      (job),
    .job_take (job_take),
    .clearing (clearing),
    .empty    (empty),
    .pop      (pop),
    .result   (result)
  );

  a_no_push_while_clearing: assert property (@(posedge clk) disable iff (rst)
    clearing |-> full)
    else $error("request accepted during ram clear");

  a_take_needs_job: assert property (@(posedge clk) disable iff (rst)
    job_take |-> (job_valid && !clearing))
    else $error("back end took a job from an empty queue");

  a_len_in_range: assert property (@(posedge clk) disable iff (rst)
    (len != '0) && (32'(len) <= LEAVES))
    else $error("effective length out of range");

endmodule

@@ sim/tb.sv @@
// testbench for the range modulo sum tree: flat array predictor, queue handshakes, scoreboard
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int LEAVES = 1024;
  localparam logic [1:0] OP_UNUSED = 2'd3;
  localparam int WD_LIMIT = 400000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic push = 1'b0;
  logic full;
  rmst_pkg::in_item_t request = '0;
  logic empty;
  logic pop = 1'b0;
  rmst_pkg::out_item_t result;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [rmst_pkg::LEN_W-1:0] cfg_data = '0;

  range_modulo_sum_tree #(.LEAVES(LEAVES)) i_dut (
    .clk(clk), .rst(rst), .push(push), .full(full), .request(request),
    .empty(empty), .pop(pop), .result(result),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  // predictor state: element values and length register
  logic [rmst_pkg::VAL_W-1:0] elem [LEAVES];
  logic [rmst_pkg::LEN_W-1:0] len_reg;
  rmst_pkg::out_item_t expected_q[$];
  int errors = 0;
  int push_idle = 0;
  int pop_idle = 0;
  int quiet_cycles = 0;

  task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
    $display("mismatch %s: got %0d expected %0d", what, got, want);
    errors++;
  endtask

  function automatic int eff_len();
    if (len_reg == 0) return 1;
    if (len_reg > LEAVES) return LEAVES;
    return int'(len_reg);
  endfunction

  // apply one request to the element array; return 1 if it gives a result
  function automatic bit predict(input rmst_pkg::in_item_t it, output rmst_pkg::out_item_t res);
    int n;
    bit ok;
    logic [rmst_pkg::SUM_W-1:0] acc;
    n = eff_len();
    ok = (it.left_index <= it.right_index) && (int'(it.right_index) < n);
    res = '0;
    if (it.operation == rmst_pkg::OP_SUM && ok) begin
      acc = '0;
      for (int i = it.left_index; i <= it.right_index; i++)
        acc += rmst_pkg::SUM_W'(elem[i]);
      res.range_total = acc;
      return 1;
    end
    if (it.operation == rmst_pkg::OP_MOD && ok && it.operand_value != 0) begin
      for (int i = it.left_index; i <= it.right_index; i++)
        elem[i] = elem[i] % it.operand_value;
      return 0;
    end
    if (it.operation == rmst_pkg::OP_SET && int'(it.left_index) < n) begin
      elem[it.left_index] = it.operand_value;
      return 0;
    end
    res.bad_request = 1'b1;
    return 1;
  endfunction

  // leaves push high after the beat; callers that stop sending drop it
  task automatic send(input logic [1:0] op, input int l, input int r, input logic [31:0] x);
    rmst_pkg::in_item_t it;
    rmst_pkg::out_item_t res;
    it.operation = op;
    it.left_index = rmst_pkg::IDX_W'(l);
    it.right_index = rmst_pkg::IDX_W'(r);
    it.operand_value = x;
    while ($urandom_range(99) < push_idle) begin
      push <= 1'b0;
      @(posedge clk);
    end
    push <= 1'b1;
    request <= it;
    @(posedge clk);
    while (full) @(posedge clk);
    if (predict(it, res)) expected_q.push_back(res);
  endtask

  // a trailing query fences everything sent before it
  task automatic drain();
    send(rmst_pkg::OP_SUM, 0, 0, 0);
    push <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk);
  endtask

  task automatic set_length(input int v);
    drain();
    cfg_valid <= 1'b1;
    cfg_data <= rmst_pkg::LEN_W'(v);
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    len_reg = rmst_pkg::LEN_W'(v);
  endtask

  // result side: pop with random stalls, compare against oldest expectation
  always @(posedge clk) begin
    if (!rst) begin
      if (pop && !empty) begin
        if (expected_q.size() == 0) begin
          report("unexpected result", 64'(result.range_total), 64'(0));
        end else begin
          if (result.range_total !== expected_q[0].range_total)
            report("range_total", 64'(result.range_total),
                   64'(expected_q[0].range_total));
          if (result.bad_request !== expected_q[0].bad_request)
            report("bad_request", 64'(result.bad_request),
                   64'(expected_q[0].bad_request));
          void'(expected_q.pop_front());
        end
      end
      pop <= ($urandom_range(99) >= pop_idle);
    end
  end

  // watchdog on cycles without any accepted beat
  always @(posedge clk) begin
    if ((push && !full) || (pop && !empty) || (cfg_valid && cfg_ready) || rst)
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles > WD_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  task automatic test_directed();
    send(rmst_pkg::OP_SUM, 0, LEAVES - 1, 0);
    send(rmst_pkg::OP_SET, 0, 0, 32'hFFFF_FFFF);
    send(rmst_pkg::OP_SET, LEAVES - 1, 0, 32'hFFFF_FFFF);
    send(rmst_pkg::OP_SET, 5, 3, 32'd1000);
    send(rmst_pkg::OP_SET, 6, 0, 32'd0);
    send(rmst_pkg::OP_SUM, 0, LEAVES - 1, 0);
    send(rmst_pkg::OP_SUM, 5, 5, 0);
    send(rmst_pkg::OP_MOD, 0, LEAVES - 1, 32'd0);
    send(rmst_pkg::OP_MOD, 4, 3, 32'd7);
    send(rmst_pkg::OP_SUM, 9, 8, 0);
    send(rmst_pkg::OP_MOD, 0, 10, 32'd7);
    send(rmst_pkg::OP_MOD, 0, 10, 32'hFFFF_FFFF);
    send(rmst_pkg::OP_MOD, LEAVES - 1, LEAVES - 1, 32'd1);
    send(rmst_pkg::OP_SUM, 0, LEAVES - 1, 0);
    send(OP_UNUSED, 0, 0, 32'd5);
    send(OP_UNUSED, 1023, 1023, 32'hFFFF_FFFF);
    send(rmst_pkg::OP_SUM, 1023, 1023, 0);
  endtask

  task automatic random_items(input int count, input int hi);
    int l, r;
    logic [1:0] op;
    logic [31:0] x;
    for (int k = 0; k < count; k++) begin
      l = $urandom_range(hi);
      r = $urandom_range(9) == 0 ? $urandom_range(1023) : l + $urandom_range(12);
      if (r > 1023) r = 1023;
      if ($urandom_range(19) == 0) l = $urandom_range(1023);
      case ($urandom_range(9))
        0, 1, 2, 3: op = rmst_pkg::OP_SET;
        4, 5, 6: op = rmst_pkg::OP_SUM;
        7, 8: op = rmst_pkg::OP_MOD;
        default: op = 2'($urandom_range(3));
      endcase
      case ($urandom_range(3))
        0: x = $urandom();
        1: x = $urandom_range(20);
        2: x = $urandom_range(1000);
        default: x = ~($urandom_range(3));
      endcase
      send(op, l, r, x);
    end
  endtask

  task automatic test_lengths();
    set_length(1);
    send(rmst_pkg::OP_SET, 0, 0, 32'd9);
    send(rmst_pkg::OP_SET, 1, 0, 32'd9);
    send(rmst_pkg::OP_SUM, 0, 1, 0);
    send(rmst_pkg::OP_SUM, 0, 0, 0);
    random_items(30, 2);
    set_length(0);
    random_items(20, 2);
    set_length(2047);
    send(rmst_pkg::OP_SUM, 0, 1023, 0);
    set_length(1025);
    random_items(20, 1023);
    set_length(17);
    random_items(60, 20);
  endtask

  task automatic test_random();
    set_length(64);
    push_idle = 26; pop_idle = 52;
    random_items(130, 70);
    // hold off until every result is back
    push <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk);
    push_idle = 52; pop_idle = 26;
    random_items(130, 70);
    push_idle = 0; pop_idle = 0;
    random_items(110, 70);
    set_length(LEAVES);
    random_items(20, 1023);
  endtask

  initial begin
    for (int i = 0; i < LEAVES; i++) elem[i] = '0;
    len_reg = rmst_pkg::LEN_W'(LEAVES);
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    test_directed();
    test_lengths();
    test_random();
    drain();
    if (errors == 0 && expected_q.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end
endmodule

@@ filelist.f @@
hw/rtl/rmst_pkg.sv
hw/rtl/rmst_ram.sv
hw/rtl/rmst_div.sv
hw/rtl/rmst_front.sv
hw/rtl/rmst_back.sv
hw/rtl/range_modulo_sum_tree.sv
sim/tb.sv
